/* rtl/shared_exclusive_lock_table_core_macros.svh */
// Assertion macros used by the lock table checker.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_CORE_MACROS_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SELT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lock table assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define SELT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lock table assertion failed");

`endif

/* rtl/selt_pkg.sv */
// Package with the types, sizes and codes of the shared/exclusive lock table.
`timescale 1ns / 1ps
package selt_pkg;

   localparam int ENTRIES   = 64;
   localparam int GATES     = 32;
   localparam int SHARE_MAX = 255;

   localparam int KEY_W  = 32;
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(SHARE_MAX + 1);
   localparam int GATE_W = (GATES > 1) ? $clog2(GATES) : 1;
   localparam int WAIT_W = 8;

   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   typedef enum logic [1:0] {
      OP_LOCK_EX   = 2'd0,
      OP_UNLOCK_EX = 2'd1,
      OP_LOCK_SH   = 2'd2,
      OP_UNLOCK_SH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE       = 3'd0,
      ST_BUSY       = 3'd1,
      ST_NOT_LOCKED = 3'd2,
      ST_FULL       = 3'd3,
      ST_SHARE_FULL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   // Lookup token that walks the cell row, collecting the first match and first free slot.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             hit;
      logic             hit_excl;
      logic [CNT_W-1:0] hit_cnt;
      logic [IDX_W-1:0] hit_idx;
      logic             free_seen;
      logic [IDX_W-1:0] free_idx;
   } probe_type;

   // Entry write broadcast to every cell; only the addressed cell takes it.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             excl;
      logic [CNT_W-1:0] cnt;
   } upd_type;

endpackage

/* rtl/selt_cell.sv */
// One lock entry cell: holds an entry and passes the lookup token to its neighbor.
`timescale 1ns / 1ps
module selt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [selt_pkg::IDX_W-1:0] cell_idx,
   input  selt_pkg::probe_type     probe_in,
   input  selt_pkg::upd_type       upd,
   output selt_pkg::probe_type     probe_out
);
   import selt_pkg::*;

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             excl_ff, excl_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   probe_type        probe_ff, probe_in_nx;
   logic             match;

   always_comb begin
      match       = probe_in.valid && valid_ff && (key_ff == probe_in.key);
      probe_in_nx = probe_in;
      if (match && !probe_in.hit) begin
         probe_in_nx.hit      = 1'b1;
         probe_in_nx.hit_excl = excl_ff;
         probe_in_nx.hit_cnt  = cnt_ff;
         probe_in_nx.hit_idx  = cell_idx;
      end
      if (probe_in.valid && !valid_ff && !probe_in.free_seen) begin
         probe_in_nx.free_seen = 1'b1;
         probe_in_nx.free_idx  = cell_idx;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      excl_in  = excl_ff;
      cnt_in   = cnt_ff;
      if (upd.en && (upd.idx == cell_idx)) begin
         valid_in = upd.valid;
         key_in   = upd.key;
         excl_in  = upd.excl;
         cnt_in   = upd.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      excl_ff <= excl_in;
      cnt_ff  <= cnt_in;
   end

   assign probe_out = probe_ff;

endmodule

/* rtl/selt_ctrl.sv */
// Request controller: launches the lookup, finds the gate, decides and updates.
`timescale 1ns / 1ps
module selt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [selt_pkg::KEY_W-1:0]  req_resource_key,
   output selt_pkg::probe_type         launch,
   input  selt_pkg::probe_type         chain_out,
   output selt_pkg::upd_type           upd,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [selt_pkg::WAIT_W-1:0] rsp_woken_waiters
);
   import selt_pkg::*;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              got_ff, got_in;
   probe_type         res_ff, res_in;
   probe_type         launch_ff, launch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WAIT_W-1:0] rsp_woken_ff, rsp_woken_in;
   logic [WAIT_W-1:0] gate_ff [GATES];
   logic              gate_we;
   logic [WAIT_W-1:0] gate_wdata;
   logic [GATE_W-1:0] gate_idx;
   logic [WAIT_W-1:0] waiters;

   // The gate count is a power of two, so the gate is the low key bits.
   assign gate_idx = GATE_W'(key_ff % KEY_W'(GATES));
   assign waiters  = gate_ff[gate_idx];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      got_in        = got_ff;
      res_in        = res_ff;
      launch_in     = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_woken_in  = rsp_woken_ff;
      upd           = '0;
      gate_we       = 1'b0;
      gate_wdata    = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = op_type'(req_op);
               key_in        = req_resource_key;
               got_in        = 1'b0;
               launch_in.valid = 1'b1;
               launch_in.key   = req_resource_key;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain_out.valid) begin
               got_in = 1'b1;
               res_in = chain_out;
            end
            if (got_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_woken_in  = '0;
            upd.key       = key_ff;
            case (op_ff)
               OP_LOCK_EX, OP_LOCK_SH: begin
                  if (!res_ff.hit) begin
                     if (!res_ff.free_seen) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        upd.en    = 1'b1;
                        upd.idx   = res_ff.free_idx;
                        upd.valid = 1'b1;
                        upd.excl  = (op_ff == OP_LOCK_EX);
                        upd.cnt   = (op_ff == OP_LOCK_EX) ? '0 : CNT_W'(1);
                     end
                  end else if ((op_ff == OP_LOCK_EX) || res_ff.hit_excl) begin
                     rsp_status_in = ST_BUSY;
                     if (waiters != WAIT_MAX) begin
                        gate_we    = 1'b1;
                        gate_wdata = waiters + 1'b1;
                     end
                  end else if (res_ff.hit_cnt >= CNT_W'(SHARE_MAX)) begin
                     rsp_status_in = ST_SHARE_FULL;
                  end else begin
                     upd.en    = 1'b1;
                     upd.idx   = res_ff.hit_idx;
                     upd.valid = 1'b1;
                     upd.cnt   = res_ff.hit_cnt + 1'b1;
                  end
               end
               OP_UNLOCK_EX: begin
                  if (!res_ff.hit || !res_ff.hit_excl) begin
                     rsp_status_in = ST_NOT_LOCKED;
                  end else begin
                     upd.en       = 1'b1;
                     upd.idx      = res_ff.hit_idx;
                     rsp_woken_in = waiters;
                     gate_we      = 1'b1;
                  end
               end
               OP_UNLOCK_SH: begin
                  if (!res_ff.hit || res_ff.hit_excl || (res_ff.hit_cnt == '0)) begin
                     rsp_status_in = ST_NOT_LOCKED;
                  end else begin
                     upd.en  = 1'b1;
                     upd.idx = res_ff.hit_idx;
                     if (res_ff.hit_cnt == CNT_W'(1)) begin
                        // Last sharer leaves: the entry is freed and the gate wakes.
                        rsp_woken_in = waiters;
                        gate_we      = 1'b1;
                     end else begin
                        upd.valid = 1'b1;
                        upd.cnt   = res_ff.hit_cnt - 1'b1;
                     end
                  end
               end
               default: begin
                  rsp_status_in = ST_NOT_LOCKED;
               end
            endcase
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         got_ff       <= 1'b0;
         for (int i = 0; i < GATES; i++) begin
            gate_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         got_ff       <= got_in;
         if (gate_we) begin
            gate_ff[gate_idx] <= gate_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign launch            = launch_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_woken_waiters = rsp_woken_ff;

endmodule

/* rtl/shared_exclusive_lock_table_core.sv */
// Top level of the shared/exclusive lock table: controller and a row of entry cells.
//
//   channel   ports                                   handshake
//   request   req_op, req_resource_key                start high while busy is low
//   result    rsp_status, rsp_woken_waiters           rsp_valid, one cycle, always taken
//
// A request runs to its end before the next can be accepted; rsp_valid rises in
// the same cycle that busy falls. The lookup token steps through one entry cell
// per cycle, plus launch, capture and decide. The gate is the low key bits and
// adds no step. Reset empties the table and clears all gate waiter counts.
// The result side has no stall; busy is high for the whole lookup.
`timescale 1ns / 1ps
module shared_exclusive_lock_table_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [selt_pkg::KEY_W-1:0]  req_resource_key,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [selt_pkg::WAIT_W-1:0] rsp_woken_waiters
);
   import selt_pkg::*;

   probe_type probe_chain [ENTRIES+1];
   upd_type   upd;

   selt_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_resource_key  (req_resource_key),
      .launch            (probe_chain[0]),
      .chain_out         (probe_chain[ENTRIES]),
      .upd               (upd),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_woken_waiters (rsp_woken_waiters)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      selt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .probe_in  (probe_chain[i]),
         .upd       (upd),
         .probe_out (probe_chain[i+1])
      );
   end

endmodule

/* rtl/selt_checker.sv */
// Port-level checker for the lock table, bound to the top level.
`timescale 1ns / 1ps
`include "shared_exclusive_lock_table_core_macros.svh"
module selt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [2:0]                  rsp_status,
   input logic [selt_pkg::WAIT_W-1:0] rsp_woken_waiters
);
   import selt_pkg::*;

   // Only a freeing unlock, which always succeeds, reports woken waiters.
   `SELT_ASSERT_NOW(a_woken_only_done, rsp_valid && (rsp_woken_waiters != '0), rsp_status == ST_DONE)
   `SELT_ASSERT_NOW(a_status_range, rsp_valid, rsp_status <= ST_SHARE_FULL)
   `SELT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `SELT_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid)
   // A result ends a lookup, so the block was busy just before it.
   `SELT_ASSERT_NOW(a_result_after_work, rsp_valid, $past(busy))

endmodule

bind shared_exclusive_lock_table_core selt_checker u_selt_checker (.*);
